// ===== design/assert_macros.svh =====
// Assertion macros used by ple_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Types, codes and sizes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] position;
    logic [31:0]      value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_index;
    logic [31:0] read_data;
    logic [4:0]  entry_count;
  } rsp_t;

  // broadcast to every cell
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [CMP_W-1:0] at;
    logic [CNT_W-1:0] count;
    elem_t            value;
  } ple_ctrl_t;

  function automatic elem_t to_elem(logic [31:0] v);
    logic [ELEM_WIDTH+31:0] w;
    w = {{ELEM_WIDTH{1'b0}}, v};
    return w[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] from_elem(elem_t e);
    logic [ELEM_WIDTH+31:0] w;
    w = {32'd0, e};
    return w[31:0];
  endfunction

endpackage

// ===== design/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Results: each result is registered into rsp, or into the skid register while rsp stalls.
// Throughput: one command per cycle; the cell row shifts or compares all
// slots in that cycle. While rsp stalls, a skid register takes one more
// command, then req stalls until the skid register drains.
// Reset: count and handshake state clear; slot contents stay undefined.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             skid_valid;
  rsp_t             skid;
  logic             accept;
  ple_ctrl_t        ctrl;
  elem_t            cell_data [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] cnt;
  logic             full;
  logic             in_range;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  rsp_t             result;
  logic [IDX_W+3:0] hit_wide;
  logic [CNT_W+4:0] count_wide;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;

  assign pos      = CMP_W'(req.position);
  assign cnt      = CMP_W'(count);
  assign full     = (count == CNT_W'(DEPTH));
  assign in_range = (pos < cnt);

  always_comb begin
    ctrl.shift_up   = accept && (req.cmd == CMD_INSERT) && !full;
    ctrl.shift_down = accept && (req.cmd == CMD_REMOVE) && in_range;
    ctrl.at         = (req.cmd == CMD_INSERT && !in_range) ? cnt : pos;
    ctrl.count      = count;
    ctrl.value      = to_elem(req.value);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    elem_t left_data;
    elem_t right_data;
    if (g == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_body
      assign left_data = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_data = '0;
    end else begin : g_next
      assign right_data = cell_data[g+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .ctrl       (ctrl),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // lowest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.shift_up) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.shift_down) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign hit_wide   = (IDX_W + 4)'(hit_idx);
  assign count_wide = (CNT_W + 5)'(count_next);

  always_comb begin
    result.status      = ST_OK;
    result.found_index = 4'd0;
    result.read_data   = 32'd0;
    result.entry_count = count_wide[4:0];
    unique case (req.cmd)
      CMD_INSERT: begin
        if (full) begin
          result.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          result.status = ST_RANGE;
        end
      end
      CMD_FIND: begin
        if (hit) begin
          result.found_index = hit_wide[3:0];
        end else begin
          result.status = ST_NOTFOUND;
        end
      end
      CMD_READ: begin
        if (in_range) begin
          result.read_data = from_elem(cell_data[pos[IDX_W-1:0]]);
        end else begin
          result.status = ST_RANGE;
        end
      end
      default: result.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (!rsp_valid || !rsp_stall) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          rsp_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp <= skid;
      end else if (accept) begin
        rsp <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

endmodule

// ===== design/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a word, takes a neighbor's word on insert or remove,
// and compares against the search value.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  ple_ctrl_t        ctrl,
  input  elem_t            left_data,
  input  elem_t            right_data,
  output elem_t            data,
  output logic             match
);

  logic [CMP_W-1:0] slot;

  assign slot = CMP_W'(idx);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      if (slot > ctrl.at) begin
        data <= left_data;
      end else if (slot == ctrl.at) begin
        data <= ctrl.value;
      end
    end else if (ctrl.shift_down) begin
      if (slot >= ctrl.at) begin
        data <= right_data;
      end
    end
  end

  assign match = (slot < CMP_W'(ctrl.count)) && (data == ctrl.value);

endmodule

// ===== design/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_checker import ple_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `ASSERT_ALWAYS(a_count_bound, clk, rst,
    !rsp_valid || (32'(rsp.entry_count) <= DEPTH), "entry count above depth")

  `ASSERT_ALWAYS(a_full_count, clk, rst,
    !(rsp_valid && rsp.status == ST_FULL) || (32'(rsp.entry_count) == DEPTH),
    "full reported with list not full")

  `ASSERT_ALWAYS(a_fail_zero, clk, rst,
    !(rsp_valid && rsp.status != ST_OK) ||
      (rsp.found_index == 4'd0 && rsp.read_data == 32'd0),
    "failed command returned data")

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
    rsp_valid && $stable(rsp), "stalled transfer changed")

  `ASSERT_NEXT(a_req_hold, clk, rst, req_valid && req_stall,
    req_valid && $stable(req), "stalled command changed")

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives list commands into positional_list_engine under several idle and
// stall mixes and checks every reply against a behavioral model of the list.
// ----------------------------------------------------------------------------
module testbench import ple_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 250000;
  localparam int RANDOM_PER_PHASE = 175;

  // Model of the list; predicts one reply per command transfer.
  class list_scoreboard;
    elem_t       slot[DEPTH];
    int unsigned fill;
    rsp_t        pending_replies[$];
    int          mismatches;

    function new();
      fill = 0;
      mismatches = 0;
      foreach (slot[i]) slot[i] = '0;
    endfunction

    function void apply_command(req_t c);
      rsp_t  r;
      elem_t v;
      int    at;
      v = elem_t'(c.value);
      r = '0;
      r.status = ST_OK;
      case (c.cmd)
        CMD_INSERT: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            at = (c.position < fill) ? int'(c.position) : int'(fill);
            for (int i = fill; i > at; i--) slot[i] = slot[i-1];
            slot[at] = v;
            fill++;
          end
        end
        CMD_REMOVE: begin
          if (c.position >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = c.position; i + 1 < fill; i++) slot[i] = slot[i+1];
            fill--;
          end
        end
        CMD_FIND: begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < fill; i++) begin
            if (slot[i] == v) begin
              r.status = ST_OK;
              r.found_index = 4'(i);
              break;
            end
          end
        end
        default: begin
          if (c.position >= fill) r.status = ST_RANGE;
          else r.read_data = 32'(slot[c.position]);
        end
      endcase
      r.entry_count = 5'(fill);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: reply with no command outstanding: st=%0d idx=%0d data=%h cnt=%0d",
                   got.status, got.found_index, got.read_data, got.entry_count);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status != want.status || got.found_index != want.found_index ||
          got.read_data != want.read_data || got.entry_count != want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: reply mismatch: expected st=%0d idx=%0d data=%h cnt=%0d, ",
                    "got st=%0d idx=%0d data=%h cnt=%0d"},
                   want.status, want.found_index, want.read_data, want.entry_count,
                   got.status, got.found_index, got.read_data, got.entry_count);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  list_scoreboard book;
  int send_idle_pct = 0;
  int reply_stall_pct = 0;
  int cycles = 0;
  bit growing = 1'b1;

  positional_list_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < reply_stall_pct);
  end

  // transfers on both channels, seen with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) book.apply_command(req);
      if (rsp_valid && !rsp_stall) book.check_reply(rsp);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic req_t make_cmd(logic [1:0] op, int pos, logic [31:0] val);
    req_t c;
    c.cmd = op;
    c.position = 5'(pos);
    c.value = val;
    return c;
  endfunction

  // Mostly in-range commands; the list swings between full and empty so
  // both ends get exercised. Count may lag by one transfer, harmless here.
  function automatic req_t pick_command();
    req_t        c;
    int unsigned n;
    int unsigned roll;
    n = book.fill;
    if (n >= DEPTH) growing = 1'b0;
    else if (n == 0) growing = 1'b1;
    roll = $urandom_range(99);
    c.value = $urandom;
    c.position = 5'($urandom_range(n));
    if (roll < 10) begin
      c.cmd = 2'($urandom_range(3));
      c.position = 5'($urandom_range(31));
    end else if (roll < (growing ? 55 : 30)) begin
      c.cmd = CMD_INSERT;
    end else if (roll < 70) begin
      c.cmd = CMD_REMOVE;
    end else if (roll < 85) begin
      c.cmd = CMD_FIND;
    end else begin
      c.cmd = CMD_READ;
    end
    roll = $urandom_range(99);
    if (n > 0 && ((c.cmd == CMD_FIND && roll < 65) || (c.cmd == CMD_INSERT && roll < 25)))
      c.value = 32'(book.slot[$urandom_range(n - 1)]);
    else if (roll >= 95)
      c.value = '1;
    else if (roll >= 90)
      c.value = '0;
    return c;
  endfunction

  task automatic send_command(input req_t c);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= c;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    reply_stall_pct = stall_pct;
    repeat (n_items) send_command(pick_command());
  endtask

  initial begin
    book = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list: remove/read out of range, find misses
    send_command(make_cmd(CMD_READ, 0, 32'h0));
    send_command(make_cmd(CMD_REMOVE, 0, 32'h0));
    send_command(make_cmd(CMD_FIND, 0, 32'h0));
    // insert far beyond count appends, insert at zero goes to the head
    send_command(make_cmd(CMD_INSERT, 31, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_INSERT, 0, 32'h0000_0000));
    for (int i = 0; i < 14; i++)
      send_command(make_cmd(CMD_INSERT, (i * 7) % 17, 32'hA5A5_0000 + 32'(i)));
    // full list
    send_command(make_cmd(CMD_INSERT, 3, 32'h1234_5678));
    send_command(make_cmd(CMD_FIND, 0, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_FIND, 0, 32'h5A5A_5A5A));
    send_command(make_cmd(CMD_READ, 15, 32'h0));
    send_command(make_cmd(CMD_READ, 16, 32'h0));
    send_command(make_cmd(CMD_REMOVE, 16, 32'h0));
    send_command(make_cmd(CMD_REMOVE, 0, 32'h0));

    run_random(RANDOM_PER_PHASE, 0, 0);
    run_random(RANDOM_PER_PHASE, 66, 0);
    run_random(RANDOM_PER_PHASE, 0, 66);
    run_random(RANDOM_PER_PHASE, 35, 35);

    req_valid <= 1'b0;
    // let the last transfer reach the model before draining
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== positional_list_engine.f =====
+incdir+design
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
design/ple_checker.sv
tb/testbench.sv
